>>> rtl/bswhc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bucketed sliding-window hit counter.
// Used by the controller, the datapath and the top level; depends on nothing.

package bswhc_pkg;

   localparam int WINDOW_DEFAULT = 256;

   localparam int TIME_W  = 31;
   localparam int COUNT_W = 16;
   localparam int SUM_W   = 24;
   localparam int ENTRY_W = TIME_W + COUNT_W;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};

   // Slot remainder: a reciprocal multiply, then a short multiply and subtract.
   localparam int MOD_STEPS = 2;
   localparam int MOD_CW    = $clog2(MOD_STEPS);

   localparam logic OP_HIT   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic clr_write;
      logic load_req;
      logic mod_step;
      logic hit_read;
      logic hit_write;
      logic scan_read;
      logic idx_advance;
      logic rsp_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic idx_last;
      logic mod_last;
   } dp_status_type;

endpackage

>>> rtl/bucketed_sliding_window_hit_counter_core.sv
`timescale 1ns / 1ps
// Bucketed sliding-window hit counter: a ring of WINDOW buckets, each a time tag and a
// saturating 16-bit count, held in one single-port-write, registered-read memory. After
// reset the block runs a clearing pass over all WINDOW buckets, one bucket a cycle, with
// req_stall high. A hit (op 0) first finds its timestamp-mod-WINDOW slot (a reciprocal
// multiply, then a short multiply and subtract on the low bits), then reads and writes
// the bucket. A query (op 1) runs a scan that reads one bucket per cycle through the
// memory read port and adds it into a saturating 24-bit sum; the result goes to an
// output register, so a new beat is accepted while the last result waits on rsp_stall.
// Hits give no result beat; req_stall stays high until a hit or a query is done.

module bucketed_sliding_window_hit_counter_core
   import bswhc_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [TIME_W-1:0]  req_timestamp,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [SUM_W-1:0]   rsp_window_hits
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   bswhc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   bswhc_dpath #(
      .WINDOW (WINDOW)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_timestamp   (req_timestamp),
      .cmd             (cmd),
      .status          (status),
      .rsp_window_hits (rsp_window_hits)
   );

   // no beat is taken while the buckets are being cleared
   a_stall_after_reset: assert property (@(posedge clock) reset |=> req_stall)
      else $error("input accepted during clearing pass");

   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid && rsp_stall))
      else $error("result register overwritten while stalled");

   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.hit_write |-> $past(cmd.hit_read))
      else $error("bucket write without preceding read");

endmodule

>>> rtl/bswhc_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine of the hit counter: clearing pass, hit update, query scan.
// Depends on bswhc_pkg for the command and status structs.

module bswhc_ctrl
   import bswhc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_op,
   output logic          req_stall,
   input  logic          rsp_stall,
   output logic          rsp_valid,
   input  dp_status_type status,
   output ctl_cmd_type   cmd
);

   typedef enum logic [7:0] {
      ST_CLEAR   = 8'b0000_0001,
      ST_IDLE    = 8'b0000_0010,
      ST_MOD     = 8'b0000_0100,
      ST_HIT_RD  = 8'b0000_1000,
      ST_HIT_WR  = 8'b0001_0000,
      ST_SCAN    = 8'b0010_0000,
      ST_DRAIN   = 8'b0100_0000,
      ST_DELIVER = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_write   = 1'b1;
            cmd.idx_advance = 1'b1;
            if (status.idx_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = (req_op == OP_QUERY) ? ST_SCAN : ST_MOD;
            end
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (status.mod_last) begin
               state_in = ST_HIT_RD;
            end
         end
         ST_HIT_RD: begin
            cmd.hit_read = 1'b1;
            state_in     = ST_HIT_WR;
         end
         ST_HIT_WR: begin
            cmd.hit_write = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_SCAN: begin
            cmd.scan_read   = 1'b1;
            cmd.idx_advance = 1'b1;
            if (status.idx_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DELIVER;
         end
         ST_DELIVER: begin
            // hold the sum until the output register frees up
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/bswhc_dpath.sv
`timescale 1ns / 1ps
// Datapath of the hit counter: bucket memory, slot remainder unit, hit update and scan sum.
// Depends on bswhc_pkg; driven by bswhc_ctrl through the command struct.

module bswhc_dpath
   import bswhc_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [TIME_W-1:0]  req_timestamp,
   input  ctl_cmd_type        cmd,
   output dp_status_type      status,
   output logic [SUM_W-1:0]   rsp_window_hits
);

   localparam int IW       = $clog2(WINDOW);
   localparam int RECIP_SH = TIME_W + IW;
   localparam int RECIP_W  = TIME_W + 1;
   localparam int PROD_W   = TIME_W + RECIP_W;
   localparam logic [63:0]              RECIP_L  = ((64'd1 << RECIP_SH) + 64'(WINDOW - 1))
                                                   / 64'(WINDOW);
   localparam logic [RECIP_W-1:0]       RECIP    = RECIP_W'(RECIP_L);
   // zero when WINDOW is a power of two, so the slot is just the low bits
   localparam logic [IW-1:0]            WIN_LO   = IW'(WINDOW);
   localparam logic [IW-1:0]            LAST_IDX = IW'(WINDOW - 1);
   localparam logic signed [TIME_W+1:0] WIN_D    = (TIME_W + 2)'(WINDOW);

   logic [ENTRY_W-1:0] mem [WINDOW];
   logic [ENTRY_W-1:0] rd_data_ff;

   logic [IW-1:0]      idx_ff;
   logic [IW-1:0]      idx_in;
   logic [MOD_CW-1:0]  mod_cnt_ff;
   logic [MOD_CW-1:0]  mod_cnt_in;
   logic               scan_vld_ff;
   logic [TIME_W-1:0]  req_time_ff;
   logic [IW-1:0]      quo_ff;
   logic [IW-1:0]      rem_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [SUM_W-1:0]   sum_in;
   logic [SUM_W-1:0]   rsp_hits_ff;

   logic [IW-1:0]             quo_in;
   logic [2*IW-1:0]           quo_win;
   logic [IW-1:0]             rem_in;
   logic [TIME_W-1:0]         rd_tag;
   logic [COUNT_W-1:0]        rd_cnt;
   logic                      tag_eq;
   logic                      tag_lt;
   logic signed [TIME_W+1:0]  diff;
   logic                      in_win;
   logic [SUM_W:0]            sum_add;
   logic                      mem_we;
   logic [IW-1:0]             mem_wa;
   logic [ENTRY_W-1:0]        mem_wd;
   logic                      mem_re;
   logic [IW-1:0]             mem_ra;
   logic [COUNT_W-1:0]        cnt_inc;

   assign status.idx_last = (idx_ff == LAST_IDX);
   assign status.mod_last = (mod_cnt_ff == MOD_CW'(MOD_STEPS - 1));
   assign rsp_window_hits = rsp_hits_ff;

   // exact quotient by reciprocal; only its low bits matter for t - q*WINDOW,
   // since the remainder is below 2**IW
   assign quo_in  = IW'((PROD_W'(req_time_ff) * PROD_W'(RECIP)) >> RECIP_SH);
   assign quo_win = {{IW{1'b0}}, quo_ff} * {{IW{1'b0}}, WIN_LO};
   assign rem_in  = req_time_ff[IW-1:0] - quo_win[IW-1:0];

   assign idx_in     = status.idx_last ? '0 : idx_ff + IW'(1);
   assign mod_cnt_in = mod_cnt_ff + MOD_CW'(1);

   assign rd_tag  = rd_data_ff[ENTRY_W-1:COUNT_W];
   assign rd_cnt  = rd_data_ff[COUNT_W-1:0];
   assign tag_eq  = (rd_tag == req_time_ff);
   assign tag_lt  = (rd_tag < req_time_ff);
   assign cnt_inc = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + COUNT_W'(1);

   // signed age of the bucket; future tags come out negative and count as inside
   assign diff    = $signed({2'b00, req_time_ff}) - $signed({2'b00, rd_tag});
   assign in_win  = (diff < WIN_D);
   assign sum_add = {1'b0, sum_ff} + (SUM_W + 1)'(in_win ? rd_cnt : '0);

   always_comb begin
      priority if (cmd.load_req) begin
         sum_in = '0;
      end else if (scan_vld_ff) begin
         sum_in = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
      end else begin
         sum_in = sum_ff;
      end
   end

   always_comb begin
      mem_we = cmd.clr_write || (cmd.hit_write && (tag_eq || tag_lt));
      mem_wa = cmd.clr_write ? idx_ff : rem_ff;
      priority if (cmd.clr_write) begin
         mem_wd = '0;
      end else if (tag_eq) begin
         mem_wd = {rd_tag, cnt_inc};
      end else begin
         mem_wd = {req_time_ff, COUNT_W'(1)};
      end
      mem_re = cmd.scan_read || cmd.hit_read;
      mem_ra = cmd.scan_read ? idx_ff : rem_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         mod_cnt_ff  <= '0;
         scan_vld_ff <= 1'b0;
      end else begin
         if (cmd.idx_advance) begin
            idx_ff <= idx_in;
         end
         if (cmd.load_req) begin
            mod_cnt_ff <= '0;
         end else if (cmd.mod_step) begin
            mod_cnt_ff <= mod_cnt_in;
         end
         scan_vld_ff <= cmd.scan_read;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_time_ff <= req_timestamp;
         rem_ff      <= '0;
      end else if (cmd.mod_step) begin
         // first step takes the quotient, the last one the slot
         if (status.mod_last) begin
            rem_ff <= rem_in;
         end else begin
            quo_ff <= quo_in;
         end
      end
      sum_ff <= sum_in;
      if (cmd.rsp_load) begin
         rsp_hits_ff <= sum_ff;
      end
   end

endmodule

>>> sim/bucketed_sliding_window_hit_counter_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for bucketed_sliding_window_hit_counter_core: a queue-fed driver,
// a monitor, a bucket-ring predictor and a no-progress watchdog.
// Depends on rtl/bswhc_pkg.sv and the core RTL.

module bucketed_sliding_window_hit_counter_core_tb;
   import bswhc_pkg::*;

   localparam int     WIN         = WINDOW_DEFAULT;
   localparam int     TOTAL_ITEMS = 1350;
   localparam int     QUIET_LIMIT = 5000;
   localparam int     PHASE_LEN   = 90;
   localparam longint TIME_TOP    = (longint'(1) << TIME_W) - 1;

   typedef struct packed {
      logic              op;
      logic [TIME_W-1:0] ts;
   } hit_req_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_op = OP_HIT;
   logic [TIME_W-1:0]  req_timestamp = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [SUM_W-1:0]   rsp_window_hits;

   // predicted bucket ring
   logic [TIME_W-1:0]  bucket_tag [WIN];
   logic [COUNT_W-1:0] bucket_cnt [WIN];

   hit_req_type        pending_q [$];
   logic [SUM_W-1:0]   window_sums_q [$];
   hit_req_type        next_beat;
   logic [SUM_W-1:0]   want_sum;
   int                 accepted_items = 0;
   int                 err_cnt = 0;
   int                 quiet_cycles = 0;
   logic [1:0]         idle_phase;

   bucketed_sliding_window_hit_counter_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_timestamp   (req_timestamp),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_window_hits (rsp_window_hits)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // rotate through the idle phases as items go in
   assign idle_phase = 2'((accepted_items / PHASE_LEN) % 4);

   function automatic int send_idle_pct(logic [1:0] ph);
      case (ph)
         2'd1:    return 58;
         2'd3:    return 22;
         default: return 0;
      endcase
   endfunction

   function automatic int recv_stall_pct(logic [1:0] ph);
      case (ph)
         2'd2:    return 58;
         2'd3:    return 22;
         default: return 0;
      endcase
   endfunction

   function automatic logic [TIME_W-1:0] clamp_time(longint v);
      if (v < 0) return '0;
      if (v > TIME_TOP) return TIME_W'(TIME_TOP);
      return TIME_W'(v);
   endfunction

   function automatic void record_hit(logic [TIME_W-1:0] t);
      int slot;
      slot = int'(t % WIN);
      if (bucket_tag[slot] == t) begin
         if (bucket_cnt[slot] != COUNT_MAX) bucket_cnt[slot] = bucket_cnt[slot] + 1'b1;
      end else if (bucket_tag[slot] < t) begin
         bucket_tag[slot] = t;
         bucket_cnt[slot] = COUNT_W'(1);
      end
      // newer tag: drop the hit
   endfunction

   function automatic logic [SUM_W-1:0] window_sum(logic [TIME_W-1:0] t);
      int unsigned acc;
      longint      age;
      acc = 0;
      for (int i = 0; i < WIN; i++) begin
         // negative age (tag in the future) still counts
         age = longint'(t) - longint'(bucket_tag[i]);
         if (age < WIN) begin
            acc += 32'(bucket_cnt[i]);
            if (acc > SUM_MAX) acc = 32'(SUM_MAX);
         end
      end
      return SUM_W'(acc);
   endfunction

   task automatic push_item(logic op, logic [TIME_W-1:0] ts);
      hit_req_type it;
      it.op = op;
      it.ts = ts;
      pending_q = {pending_q, it};
   endtask

   // driver: predict on each accepted beat, then load the next one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req_op == OP_QUERY) window_sums_q = {window_sums_q, window_sum(req_timestamp)};
            else record_hit(req_timestamp);
            accepted_items <= accepted_items + 1;
         end
         if (!req_valid || !req_stall) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct(idle_phase)) begin
               next_beat = pending_q.pop_front();
               req_valid <= 1'b1;
               req_op <= next_beat.op;
               req_timestamp <= next_beat.ts;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (window_sums_q.size() == 0) begin
               $display("%0t: unexpected result beat, actual window_hits %0d",
                        $time, rsp_window_hits);
               err_cnt++;
            end else begin
               want_sum = window_sums_q.pop_front();
               if (rsp_window_hits !== want_sum) begin
                  $display("%0t: window_hits mismatch, expected %0d actual %0d",
                           $time, want_sum, rsp_window_hits);
                  err_cnt++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct(idle_phase));
      end
   end

   // watchdog: count cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: timeout, no beat for %0d cycles", $time, quiet_cycles);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      longint now_t;
      int     burst;
      int     r;
      for (int i = 0; i < WIN; i++) begin
         bucket_tag[i] = '0;
         bucket_cnt[i] = '0;
      end

      // directed: empty ring, time zero, retag, stale drop, future tags, top of range
      push_item(OP_QUERY, TIME_W'(0));
      push_item(OP_HIT, TIME_W'(0));
      push_item(OP_HIT, TIME_W'(0));
      push_item(OP_QUERY, TIME_W'(0));
      push_item(OP_HIT, TIME_W'(255));
      push_item(OP_HIT, TIME_W'(256));
      push_item(OP_HIT, TIME_W'(0));
      push_item(OP_QUERY, TIME_W'(256));
      push_item(OP_QUERY, TIME_W'(0));
      push_item(OP_QUERY, TIME_W'(511));
      push_item(OP_QUERY, TIME_W'(512));
      push_item(OP_HIT, TIME_W'(TIME_TOP));
      push_item(OP_HIT, TIME_W'(TIME_TOP));
      push_item(OP_QUERY, TIME_W'(TIME_TOP));
      push_item(OP_QUERY, TIME_W'(0));
      push_item(OP_HIT, 31'h7FFF_FF00);
      push_item(OP_QUERY, TIME_W'(TIME_TOP));
      push_item(OP_HIT, 31'h5555_5555);
      push_item(OP_HIT, 31'h2AAA_AAAA);
      push_item(OP_QUERY, 31'h5555_5555);
      push_item(OP_QUERY, 31'h2AAA_AAAA);

      // random: bursts of hits around a slowly moving time, then a query or two
      now_t = 0;
      while (pending_q.size() < TOTAL_ITEMS) begin
         r = $urandom_range(99);
         if (r < 3) now_t = longint'($urandom() & 32'h7FFF_FFFF);
         else if (r < 5) now_t = TIME_TOP - longint'($urandom_range(700));
         else if (r < 7) now_t = longint'($urandom_range(700));
         else if (r < 12) now_t = now_t - longint'($urandom_range(400));
         else now_t = now_t + longint'($urandom_range(40));
         now_t = clamp_time(now_t);
         burst = $urandom_range(12, 1);
         for (int k = 0; k < burst; k++) begin
            if ($urandom_range(2) == 0) now_t = clamp_time(now_t + longint'($urandom_range(3)));
            if ($urandom_range(9) == 0)
               push_item(OP_HIT, clamp_time(now_t - longint'($urandom_range(300))));
            else
               push_item(OP_HIT, clamp_time(now_t));
         end
         repeat ($urandom_range(2, 1))
            push_item(OP_QUERY, clamp_time(now_t + longint'($urandom_range(900)) - 300));
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || req_valid || window_sums_q.size() != 0)
         @(posedge clock);
      // hold for a full scan to catch any stray beat
      repeat (WIN + 40) @(posedge clock);

      if (err_cnt == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
